/* rtl/etbs_pkg.sv */
package etbs_pkg;

   localparam int RUN_COUNT_WIDTH     = 32;
   localparam int THRESHOLD_WIDTH     = 32;
   localparam int COUNT_WIDTH_DEFAULT = 32;
   localparam int QUEUE_DEPTH_DEFAULT = 4;
   localparam int REQ_DATA_WIDTH      = 8;
   localparam int RSP_DATA_WIDTH      = ((RUN_COUNT_WIDTH + 1 + 7) / 8) * 8;

   typedef enum logic {
      REQ_BIT   = 1'b0,
      REQ_FLUSH = 1'b1
   } req_kind_type;

   typedef enum logic {
      SINK_ONOFF  = 1'b0,
      SINK_MARKOV = 1'b1
   } sink_type;

   typedef struct packed {
      sink_type                   sink;
      logic                       run_value;
      logic [RUN_COUNT_WIDTH-1:0] run_count;
   } run_rec_type;

   // One queue entry holds every record that a single input beat produced.
   typedef struct packed {
      logic        pair;
      run_rec_type rec0;
      run_rec_type rec1;
   } queue_entry_type;

   typedef struct packed {
      logic            valid;
      queue_entry_type entry;
   } queue_push_type;

   typedef struct packed {
      logic            empty;
      logic            full;
      queue_entry_type head;
   } queue_status_type;

endpackage

/* rtl/error_trace_burst_segmenter.sv */
// Error-trace burst segmenter. Each request beat carries one trace bit (1 error-free,
// 0 error) or an end-of-trace flush, and causes zero, one or two run records on the
// response channel, the final one of each beat marked by tlast. A request beat is taken
// every cycle while the record queue has room; the response side delivers one record
// per cycle while the receiver is ready, so a beat that produces two records takes two
// response transfers, and the sustained beat rate depends on the trace pattern.
// The burst threshold may be rewritten only while the block is idle.
module error_trace_burst_segmenter
   import etbs_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [REQ_DATA_WIDTH-1:0]  req_tdata,   // [0] bit_value, rest zero
   input  logic                       req_tuser,   // [0] req_type
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [THRESHOLD_WIDTH-1:0] csr_data,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [RSP_DATA_WIDTH-1:0]  rsp_tdata,   // [0] run_value, [32:1] run_count
   output logic                       rsp_tuser,   // [0] sink
   output logic                       rsp_tlast
);

   queue_push_type   push;
   queue_status_type status;
   logic             pop;

   etbs_front #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_kind   (req_tuser),
      .bit_value  (req_tdata[0]),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .queue_full (status.full),
      .push       (push)
   );

   etbs_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .pop    (pop),
      .status (status)
   );

   etbs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .status     (status),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

/* rtl/etbs_front.sv */
module etbs_front
   import etbs_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic                       req_kind,
   input  logic                       bit_value,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [THRESHOLD_WIDTH-1:0] csr_data,
   input  logic                       queue_full,
   output queue_push_type             push
);

   typedef logic [COUNT_WIDTH-1:0] count_type;

   localparam count_type ONE = COUNT_WIDTH'(1);

   logic                       prev_bit_ff, prev_bit_in;
   count_type                  run_len_ff, run_len_in;
   count_type                  pend_len_ff, pend_len_in;
   logic [THRESHOLD_WIDTH-1:0] threshold_ff;

   count_type   len_inc;
   count_type   pend_sum;
   logic        run_long;
   logic        inc_long;
   logic        one_long;
   logic        accept;
   logic [1:0]  num_rec;
   run_rec_type rec0;
   run_rec_type rec1;

   function automatic count_type sat_add(count_type a, count_type b);
      logic [COUNT_WIDTH:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[COUNT_WIDTH] ? '1 : sum[COUNT_WIDTH-1:0];
   endfunction

   function automatic run_rec_type make_rec(sink_type sink, logic value, count_type count);
      run_rec_type r;
      logic [63:0] wide;
      wide        = 64'(count);
      r.sink      = sink;
      r.run_value = value;
      r.run_count = (|wide[63:RUN_COUNT_WIDTH]) ? '1 : wide[RUN_COUNT_WIDTH-1:0];
      return r;
   endfunction

   assign req_tready = !queue_full;
   assign csr_ready  = 1'b1;
   assign accept     = req_tvalid && !queue_full;

   assign len_inc  = sat_add(run_len_ff, ONE);
   assign pend_sum = sat_add(pend_len_ff, run_len_ff);
   assign run_long = 64'(run_len_ff) > 64'(threshold_ff);
   assign inc_long = 64'(len_inc) > 64'(threshold_ff);
   assign one_long = threshold_ff == '0;

   always_comb begin
      prev_bit_in = prev_bit_ff;
      run_len_in  = run_len_ff;
      pend_len_in = pend_len_ff;
      num_rec     = 2'd0;
      rec0        = '0;
      rec1        = '0;
      if (req_kind_type'(req_kind) == REQ_FLUSH) begin
         if (prev_bit_ff) begin
            if (run_long && pend_len_ff == '0) begin
               rec0    = make_rec(SINK_ONOFF, 1'b1, run_len_ff);
               num_rec = 2'd1;
            end else begin
               rec0    = make_rec(SINK_MARKOV, 1'b1, run_len_ff);
               rec1    = make_rec(SINK_ONOFF, 1'b0, pend_sum);
               num_rec = 2'd2;
            end
         end else if (pend_sum != '0) begin
            rec0    = make_rec(SINK_ONOFF, 1'b0, pend_sum);
            num_rec = 2'd1;
         end
         prev_bit_in = 1'b0;
         run_len_in  = '0;
         pend_len_in = '0;
      end else if (bit_value == prev_bit_ff) begin
         run_len_in = len_inc;
         if (!bit_value) begin
            rec0    = make_rec(SINK_MARKOV, 1'b0, ONE);
            num_rec = 2'd1;
         end else if (inc_long && pend_len_ff != '0) begin
            // The free run just grew past the threshold: close the burst early.
            rec0        = make_rec(SINK_ONOFF, 1'b0, pend_len_ff);
            num_rec     = 2'd1;
            pend_len_in = '0;
         end
      end else if (prev_bit_ff) begin
         if (run_long && pend_len_ff == '0) begin
            rec0 = make_rec(SINK_ONOFF, 1'b1, run_len_ff);
         end else begin
            rec0        = make_rec(SINK_MARKOV, 1'b1, run_len_ff);
            pend_len_in = pend_sum;
         end
         rec1        = make_rec(SINK_MARKOV, 1'b0, ONE);
         num_rec     = 2'd2;
         run_len_in  = ONE;
         prev_bit_in = 1'b0;
      end else begin
         run_len_in  = ONE;
         prev_bit_in = 1'b1;
         if (one_long && pend_sum != '0) begin
            rec0        = make_rec(SINK_ONOFF, 1'b0, pend_sum);
            num_rec     = 2'd1;
            pend_len_in = '0;
         end else begin
            pend_len_in = pend_sum;
         end
      end
   end

   always_comb begin
      push.valid      = accept && num_rec != 2'd0;
      push.entry.pair = num_rec == 2'd2;
      push.entry.rec0 = rec0;
      push.entry.rec1 = rec1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_bit_ff  <= 1'b0;
         run_len_ff   <= '0;
         pend_len_ff  <= '0;
         threshold_ff <= '0;
      end else begin
         if (accept) begin
            prev_bit_ff <= prev_bit_in;
            run_len_ff  <= run_len_in;
            pend_len_ff <= pend_len_in;
         end
         if (csr_valid) begin
            threshold_ff <= csr_data;
         end
      end
   end

endmodule

/* rtl/etbs_queue.sv */
module etbs_queue
   import etbs_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  queue_push_type   push,
   input  logic             pop,
   output queue_status_type status
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   queue_entry_type         entries_ff [DEPTH];
   logic [IDX_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [IDX_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic                    do_push;
   logic                    do_pop;

   assign do_push = push.valid && !status.full;
   assign do_pop  = pop && !status.empty;

   always_comb begin
      status.empty = count_ff == '0;
      status.full  = count_ff == CNT_W'(DEPTH);
      status.head  = entries_ff[rd_ptr_ff];
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + IDX_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + IDX_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push.entry;
      end
   end

endmodule

/* rtl/etbs_back.sv */
module etbs_back
   import etbs_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  queue_status_type          status,
   output logic                      pop,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RSP_DATA_WIDTH-1:0] rsp_tdata,
   output logic                      rsp_tuser,
   output logic                      rsp_tlast
);

   logic        sel_ff, sel_in;
   logic        rsp_valid_ff, rsp_valid_in;
   run_rec_type rsp_rec_ff;
   logic        rsp_last_ff;
   run_rec_type cur_rec;
   logic        cur_last;
   logic        load;

   assign cur_rec  = sel_ff ? status.head.rec1 : status.head.rec0;
   assign cur_last = !status.head.pair || sel_ff;
   assign load     = !status.empty && (!rsp_valid_ff || rsp_tready);
   assign pop      = load && cur_last;

   always_comb begin
      sel_in       = sel_ff;
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         sel_in       = !cur_last;
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sel_ff       <= sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_rec_ff  <= cur_rec;
         rsp_last_ff <= cur_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_WIDTH'({rsp_rec_ff.run_count, rsp_rec_ff.run_value});
   assign rsp_tuser  = rsp_rec_ff.sink;
   assign rsp_tlast  = rsp_last_ff;

endmodule
